/* rtl/sur_pkg.sv */
// shared types, register codes and tables of the sound unit register sequencer
package sur_pkg;

  localparam bit POST_BOOT_DEFAULTS = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam int unsigned CtrlRegs = 32;
  localparam int unsigned WaveRegs = 16;

  localparam logic [5:0] ADDR_FIRST = 6'h10;
  localparam logic [5:0] ADDR_WAVE  = 6'h30;
  localparam logic [5:0] ADDR_NR52  = 6'h26;

  localparam logic [4:0] IDX_NR10 = 5'd0;
  localparam logic [4:0] IDX_NR13 = 5'd3;
  localparam logic [4:0] IDX_NR14 = 5'd4;
  localparam logic [4:0] IDX_NR30 = 5'd10;
  localparam logic [4:0] IDX_NR52 = 5'd22;

  localparam logic [7:0] DAC_BITS    = 8'hF8;
  localparam int unsigned LenEnBit   = 6;
  localparam int unsigned TrigBit    = 7;
  localparam int unsigned PowerBit   = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] bus_address;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  channels_active;
    logic [3:0]  square1_level;
    logic [3:0]  square2_level;
    logic [3:0]  noise_level;
    logic [10:0] square1_freq_code;
  } out_word_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } wave_wr_t;

  function automatic logic [3:0] period_of(input logic [2:0] code);
    return (code == 3'd0) ? 4'd8 : {1'b0, code};
  endfunction

  function automatic logic [7:0] read_mask(input logic [4:0] idx);
    logic [7:0] m;
    unique case (idx)
      5'd0: m = 8'h80;   5'd1: m = 8'h3F;   5'd2: m = 8'h00;   5'd3: m = 8'hFF;
      5'd4: m = 8'hBF;   5'd5: m = 8'hFF;   5'd6: m = 8'h3F;   5'd7: m = 8'h00;
      5'd8: m = 8'hFF;   5'd9: m = 8'hBF;   5'd10: m = 8'h7F;  5'd11: m = 8'hFF;
      5'd12: m = 8'h9F;  5'd13: m = 8'hFF;  5'd14: m = 8'hBF;  5'd15: m = 8'hFF;
      5'd16: m = 8'hFF;  5'd17: m = 8'h00;  5'd18: m = 8'h00;  5'd19: m = 8'hBF;
      5'd20: m = 8'h00;  5'd21: m = 8'h00;  5'd22: m = 8'h70;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] reset_value(input logic [4:0] idx);
    logic [7:0] v;
    v = 8'h00;
    if (POST_BOOT_DEFAULTS) begin
      unique case (idx)
        5'd0: v = 8'h80;   5'd1: v = 8'hBF;   5'd2: v = 8'hF3;   5'd4: v = 8'hBF;
        5'd6: v = 8'h3F;   5'd9: v = 8'hBF;   5'd10: v = 8'h7F;  5'd11: v = 8'hFF;
        5'd12: v = 8'h9F;  5'd13: v = 8'hBF;  5'd16: v = 8'hFF;  5'd19: v = 8'hBF;
        5'd20: v = 8'h77;  5'd21: v = 8'hF3;  5'd22: v = 8'hF1;
        default: v = 8'h00;
      endcase
    end
    return v;
  endfunction

  function automatic logic [4:0] nrx4_idx(input logic [1:0] ch);
    return 5'd4 + 5'(ch) * 5'd5;
  endfunction

  function automatic logic [4:0] env_idx(input logic [1:0] slot);
    logic [4:0] r;
    unique case (slot)
      2'd0:    r = 5'd2;
      2'd1:    r = 5'd7;
      default: r = 5'd17;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] env_slot(input logic [1:0] ch);
    return (ch == 2'd3) ? 2'd2 : {1'b0, ch[0]};
  endfunction

  function automatic logic [1:0] slot_chan(input logic [1:0] slot);
    return (slot == 2'd2) ? 2'd3 : slot;
  endfunction

  function automatic logic [8:0] len_reload(input logic [1:0] ch);
    return (ch == 2'd2) ? 9'd256 : 9'd64;
  endfunction

  function automatic logic [11:0] sweep_next(input logic [7:0] nr10, input logic [10:0] shadow);
    logic [10:0] delta;
    delta = shadow >> nr10[2:0];
    return nr10[3] ? ({1'b0, shadow} - {1'b0, delta}) : ({1'b0, shadow} + {1'b0, delta});
  endfunction

endpackage

/* rtl/sur_wave_ram.sv */
// wave sample memory with registered read and post-boot pattern until written
module sur_wave_ram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [3:0]         rd_addr_i,
  input  sur_pkg::wave_wr_t  wr_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0]  mem [sur_pkg::WaveRegs];
  logic [15:0] written_q;
  logic [7:0]  rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_i.en) begin
      written_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= written_q[rd_addr_i] ? mem[rd_addr_i] : {8{rd_addr_i[0]}};
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/sur_core.sv */
// register file, length, envelope and sweep state with the per-word update
module sur_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  sur_pkg::in_word_t   item_i,
  input  logic [7:0]          wave_data_i,
  output sur_pkg::wave_wr_t   wave_wr_o,
  output sur_pkg::out_word_t  result_o
);

  logic [7:0] rf_q  [sur_pkg::CtrlRegs];
  logic [7:0] rf_d  [sur_pkg::CtrlRegs];
  logic [8:0] lc_q  [4];
  logic [8:0] lc_d  [4];
  logic [3:0] el_q  [3];
  logic [3:0] el_d  [3];
  logic [3:0] ec_q  [3];
  logic [3:0] ec_d  [3];
  logic [2:0] es_q, es_d;
  logic [3:0] swc_q, swc_d;
  logic [10:0] sws_q, sws_d;
  logic       swon_q, swon_d, neg_q, neg_d;
  logic [2:0] step_q, step_d;

  logic [5:0]  a;
  logic [7:0]  v, old, envr;
  logic [4:0]  idx;
  logic [1:0]  ch, slot;
  logic [2:0]  part, per;
  logic        is_ch, dac;
  logic [11:0] nf;
  logic [7:0]  rdata;

  always_comb begin
    rf_d = rf_q;  lc_d = lc_q;  el_d = el_q;  ec_d = ec_q;  es_d = es_q;
    swc_d = swc_q;  sws_d = sws_q;  swon_d = swon_q;  neg_d = neg_q;  step_d = step_q;
    a = item_i.bus_address;
    v = item_i.write_data;
    idx = 5'(a - sur_pkg::ADDR_FIRST);
    old = rf_q[idx];
    envr = '0;  ch = '0;  slot = '0;  part = '0;  per = '0;  is_ch = 1'b0;  dac = 1'b0;
    nf = '0;  rdata = '0;  wave_wr_o = '0;
    if (exec_i) begin
      unique case (item_i.kind)
        sur_pkg::KIND_READ: begin
          if (a < sur_pkg::ADDR_FIRST) begin
            rdata = 8'hFF;
          end else if (a >= sur_pkg::ADDR_WAVE) begin
            rdata = rf_q[sur_pkg::IDX_NR52][2] ? 8'hFF : wave_data_i;
          end else begin
            rdata = rf_q[idx] | sur_pkg::read_mask(idx);
          end
        end
        sur_pkg::KIND_WRITE: begin
          if (a == sur_pkg::ADDR_NR52) begin
            if (rf_q[sur_pkg::IDX_NR52][sur_pkg::PowerBit] && !v[sur_pkg::PowerBit]) begin
              for (int i = 0; i <= 22; i++) begin
                rf_d[i] = '0;
              end
            end else if (!rf_q[sur_pkg::IDX_NR52][sur_pkg::PowerBit] &&
                         v[sur_pkg::PowerBit]) begin
              rf_d[sur_pkg::IDX_NR52][sur_pkg::PowerBit] = 1'b1;
              step_d = '0;
            end
          end else if (a < sur_pkg::ADDR_FIRST ||
                       !rf_q[sur_pkg::IDX_NR52][sur_pkg::PowerBit]) begin
            rdata = '0;
          end else if (a >= sur_pkg::ADDR_WAVE) begin
            wave_wr_o.en   = !rf_q[sur_pkg::IDX_NR52][2];
            wave_wr_o.addr = a[3:0];
            wave_wr_o.data = v;
          end else begin
            is_ch = 1'b1;
            if (a <= 6'h14) begin
              ch = 2'd0;  part = 3'(a - 6'h10);
            end else if (a >= 6'h16 && a <= 6'h19) begin
              ch = 2'd1;  part = 3'(a - 6'h15);
            end else if (a >= 6'h1A && a <= 6'h1E) begin
              ch = 2'd2;  part = 3'(a - 6'h1A);
            end else if (a >= 6'h20 && a <= 6'h23) begin
              ch = 2'd3;  part = 3'(a - 6'h1F);
            end else begin
              is_ch = 1'b0;
            end
            rf_d[idx] = v;
            slot = sur_pkg::env_slot(ch);
            if (is_ch) begin
              case (part)
                3'd0: begin
                  if (ch == 2'd0) begin
                    if (old[3] && !v[3] && neg_q) rf_d[sur_pkg::IDX_NR52][0] = 1'b0;
                  end else if (!rf_d[sur_pkg::IDX_NR30][7]) begin
                    rf_d[sur_pkg::IDX_NR52][2] = 1'b0;
                  end
                end
                3'd1: begin
                  lc_d[ch] = sur_pkg::len_reload(ch) -
                             ({1'b0, v} & (sur_pkg::len_reload(ch) - 9'd1));
                end
                3'd2: begin
                  if (ch != 2'd2 && (rf_d[sur_pkg::env_idx(slot)] & sur_pkg::DAC_BITS) == '0)
                    rf_d[sur_pkg::IDX_NR52][ch] = 1'b0;
                end
                3'd4: begin
                  if (step_q[0] && lc_d[ch] != '0 && !old[sur_pkg::LenEnBit] &&
                      v[sur_pkg::LenEnBit]) begin
                    lc_d[ch] = lc_d[ch] - 9'd1;
                    if (lc_d[ch] == '0 && !v[sur_pkg::TrigBit])
                      rf_d[sur_pkg::IDX_NR52][ch] = 1'b0;
                  end
                  if (v[sur_pkg::TrigBit]) begin
                    rf_d[sur_pkg::IDX_NR52][ch] = 1'b1;
                    if (lc_d[ch] == '0) begin
                      lc_d[ch] = sur_pkg::len_reload(ch);
                      if (rf_d[sur_pkg::nrx4_idx(ch)][sur_pkg::LenEnBit] && step_q[0])
                        lc_d[ch] = lc_d[ch] - 9'd1;
                    end
                    if (ch != 2'd2) begin
                      envr = rf_d[sur_pkg::env_idx(slot)];
                      es_d[slot] = 1'b0;
                      ec_d[slot] = sur_pkg::period_of(envr[2:0]) +
                                   {3'd0, step_q == 3'd7};
                      el_d[slot] = envr[7:4];
                      if (ch == 2'd0) begin
                        per = rf_d[sur_pkg::IDX_NR10][6:4];
                        neg_d = 1'b0;
                        swc_d = sur_pkg::period_of(per);
                        sws_d = {rf_d[sur_pkg::IDX_NR14][2:0], rf_d[sur_pkg::IDX_NR13]};
                        swon_d = (per != '0) || (rf_d[sur_pkg::IDX_NR10][2:0] != '0);
                        if (rf_d[sur_pkg::IDX_NR10][2:0] != '0) begin
                          nf = sur_pkg::sweep_next(rf_d[sur_pkg::IDX_NR10], sws_d);
                          if (rf_d[sur_pkg::IDX_NR10][3]) neg_d = 1'b1;
                          if (nf[11]) rf_d[sur_pkg::IDX_NR52][0] = 1'b0;
                        end
                      end
                      dac = (rf_d[sur_pkg::env_idx(slot)] & sur_pkg::DAC_BITS) != '0;
                    end else begin
                      dac = rf_d[sur_pkg::IDX_NR30][7];
                    end
                    if (!dac) rf_d[sur_pkg::IDX_NR52][ch] = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        sur_pkg::KIND_TICK: begin
          if (rf_q[sur_pkg::IDX_NR52][sur_pkg::PowerBit]) begin
            if (step_q == 3'd0 || step_q == 3'd2 || step_q == 3'd4 || step_q == 3'd6) begin
              for (int c = 0; c < 4; c++) begin
                if (rf_d[sur_pkg::IDX_NR52][c] &&
                    rf_d[sur_pkg::nrx4_idx(2'(c))][sur_pkg::LenEnBit] && lc_d[c] != '0) begin
                  lc_d[c] = lc_d[c] - 9'd1;
                  if (lc_d[c] == '0) rf_d[sur_pkg::IDX_NR52][c] = 1'b0;
                end
              end
            end
            if ((step_q == 3'd2 || step_q == 3'd6) &&
                rf_d[sur_pkg::IDX_NR52][0] && swon_q) begin
              swc_d = swc_q - 4'd1;
              if (swc_d == '0) begin
                per = rf_d[sur_pkg::IDX_NR10][6:4];
                swc_d = sur_pkg::period_of(per);
                if (per != '0) begin
                  nf = sur_pkg::sweep_next(rf_d[sur_pkg::IDX_NR10], sws_d);
                  if (rf_d[sur_pkg::IDX_NR10][3]) neg_d = 1'b1;
                  if (nf[11]) begin
                    rf_d[sur_pkg::IDX_NR52][0] = 1'b0;
                  end else if (rf_d[sur_pkg::IDX_NR10][2:0] != '0) begin
                    sws_d = nf[10:0];
                    rf_d[sur_pkg::IDX_NR13] = nf[7:0];
                    rf_d[sur_pkg::IDX_NR14] = {rf_d[sur_pkg::IDX_NR14][7:3], nf[10:8]};
                  end
                  nf = sur_pkg::sweep_next(rf_d[sur_pkg::IDX_NR10], sws_d);
                  if (nf[11]) rf_d[sur_pkg::IDX_NR52][0] = 1'b0;
                end
              end
            end
            if (step_q == 3'd7) begin
              for (int s = 0; s < 3; s++) begin
                if (rf_d[sur_pkg::IDX_NR52][sur_pkg::slot_chan(2'(s))] && !es_q[s]) begin
                  ec_d[s] = ec_q[s] - 4'd1;
                  if (ec_d[s] == '0) begin
                    envr = rf_d[sur_pkg::env_idx(2'(s))];
                    ec_d[s] = sur_pkg::period_of(envr[2:0]);
                    if (envr[2:0] != '0) begin
                      if (envr[3]) begin
                        if (el_q[s] != 4'd15) el_d[s] = el_q[s] + 4'd1;
                        else es_d[s] = 1'b1;
                      end else begin
                        if (el_q[s] != 4'd0) el_d[s] = el_q[s] - 4'd1;
                        else es_d[s] = 1'b1;
                      end
                    end
                  end
                end
              end
            end
            step_d = step_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
    result_o.read_data         = rdata;
    result_o.channels_active   = rf_d[sur_pkg::IDX_NR52][3:0];
    result_o.square1_level     = el_d[0];
    result_o.square2_level     = el_d[1];
    result_o.noise_level       = el_d[2];
    result_o.square1_freq_code = {rf_d[sur_pkg::IDX_NR14][2:0], rf_d[sur_pkg::IDX_NR13]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sur_pkg::CtrlRegs; i++) begin
        rf_q[i] <= sur_pkg::reset_value(5'(i));
      end
      for (int c = 0; c < 4; c++) begin
        lc_q[c] <= '0;
      end
      for (int s = 0; s < 3; s++) begin
        el_q[s] <= '0;
        ec_q[s] <= '0;
      end
      es_q <= '0;  swc_q <= '0;  sws_q <= '0;  swon_q <= 1'b0;  neg_q <= 1'b0;
      step_q <= '0;
    end else if (exec_i) begin
      rf_q <= rf_d;  lc_q <= lc_d;  el_q <= el_d;  ec_q <= ec_d;  es_q <= es_d;
      swc_q <= swc_d;  sws_q <= sws_d;  swon_q <= swon_d;  neg_q <= neg_d;
      step_q <= step_d;
    end
  end

  a_off_no_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rf_q[sur_pkg::IDX_NR52][sur_pkg::PowerBit] |-> rf_q[sur_pkg::IDX_NR52][3:0] == '0)
    else $error("channel active while powered off");

  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_i |=> $stable(step_q))
    else $error("sequencer step moved without a word");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_q[0] <= 9'd64 && lc_q[2] <= 9'd256)
    else $error("length counter beyond reload");

endmodule

/* rtl/sound_unit_register_sequencer_unit.sv */
// top level of the sound unit register sequencer: handshake, result register
// The accepted word is captured in the item register while the wave-RAM read is
// issued; the core then applies the read, write or sequencer tick to the register
// file and channel state and loads the result register. No new word is taken
// while the core is busy with the last one, nor while a held result is stalled.
// After reset the registers hold their post-boot values and no clearing pass runs.
module sound_unit_register_sequencer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sur_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sur_pkg::out_word_t out_word_o
);

  logic               busy_q;
  logic               out_valid_q;
  sur_pkg::in_word_t  item_q;
  sur_pkg::out_word_t out_word_q;
  sur_pkg::out_word_t result;
  sur_pkg::wave_wr_t  wave_wr;
  logic [7:0]         wave_data;
  logic               accept;

  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  sur_wave_ram u_wave (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_word_i.bus_address[3:0]),
    .wr_i      (wave_wr),
    .rd_data_o (wave_data)
  );

  sur_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exec_i      (busy_q),
    .item_i      (item_q),
    .wave_data_i (wave_data),
    .wave_wr_o   (wave_wr),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= accept;
      if (busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    if (busy_q) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
